// ===== rtl/core/mlfr_pkg.sv =====
// Package of shared types and constants for the link frame receiver.
`timescale 1ns / 1ps

package mlfr_pkg;

   // Longest payload run that aborts a frame, and the payload memory geometry.
   localparam int MAX_DATA    = 64;
   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = 6;

   localparam int BYTE_W = 8;
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 4;

   // The device id that is always accepted besides the broadcast id.
   localparam logic [BYTE_W-1:0] DEVICE_ID_SELF = 8'd1;
   localparam logic [BYTE_W-1:0] BROADCAST_RESET = 8'd254;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_OWN_ADDRESS       = 2'd0,
      REG_SENDER_A          = 2'd1,
      REG_SENDER_B          = 2'd2,
      REG_BROADCAST_ADDRESS = 2'd3
   } mlfr_reg_type;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_SENDER,
      ST_DEVICE,
      ST_PACKET,
      ST_LENGTH,
      ST_PAYLOAD,
      ST_CHECK,
      ST_REPLAY_READ,
      ST_REPLAY_LOAD
   } mlfr_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] own_address;
      logic [BYTE_W-1:0] sender_a;
      logic [BYTE_W-1:0] sender_b;
      logic [BYTE_W-1:0] broadcast_address;
   } mlfr_cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sum_load;
      logic sum_add;
      logic src_load;
      logic pkt_load;
      logic len_load;
      logic store_write;
      logic idx_clear;
      logic idx_inc;
      logic rd_issue;
      logic out_load;
   } mlfr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic own_match;
      logic sender_match;
      logic device_match;
      logic len_zero;
      logic count_done;
      logic count_overflow;
      logic sum_ok;
      logic replay_last;
      logic out_free;
   } mlfr_status_type;

endpackage

// ===== rtl/core/mlfr_if.sv =====
// Channel interfaces for received bytes and for frame results.
`timescale 1ns / 1ps

interface mlfr_req_if
   import mlfr_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfr_rsp_if
   import mlfr_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  source_id;
   logic [BYTE_W-1:0]  packet_id;
   logic [COUNT_W-1:0] payload_length;
   logic [COUNT_W-1:0] byte_index;
   logic [BYTE_W-1:0]  payload_byte;
   logic               last;

   modport source (output valid, output source_id, output packet_id, output payload_length,
                   output byte_index, output payload_byte, output last, input ready);
   modport sink   (input valid, input source_id, input packet_id, input payload_length,
                   input byte_index, input payload_byte, input last, output ready);
endinterface

// ===== rtl/core/mlfr_csr.sv =====
// Configuration register file of the link frame receiver.
`timescale 1ns / 1ps

module mlfr_csr
   import mlfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output mlfr_cfg_type      cfg
);

   mlfr_cfg_type cfg_ff, cfg_in;
   mlfr_reg_type reg_index;
   logic         write_en;

   assign reg_index  = mlfr_reg_type'(csr_paddr[CSR_AW-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_OWN_ADDRESS:       cfg_in.own_address       = csr_pwdata[BYTE_W-1:0];
            REG_SENDER_A:          cfg_in.sender_a          = csr_pwdata[BYTE_W-1:0];
            REG_SENDER_B:          cfg_in.sender_b          = csr_pwdata[BYTE_W-1:0];
            REG_BROADCAST_ADDRESS: cfg_in.broadcast_address = csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_OWN_ADDRESS:       csr_prdata = CSR_DW'(cfg_ff.own_address);
         REG_SENDER_A:          csr_prdata = CSR_DW'(cfg_ff.sender_a);
         REG_SENDER_B:          csr_prdata = CSR_DW'(cfg_ff.sender_b);
         REG_BROADCAST_ADDRESS: csr_prdata = CSR_DW'(cfg_ff.broadcast_address);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address       <= '0;
         cfg_ff.sender_a          <= '0;
         cfg_ff.sender_b          <= '0;
         cfg_ff.broadcast_address <= BROADCAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/mlfr_ctrl.sv =====
// Frame hunting and replay state machine of the link frame receiver.
`timescale 1ns / 1ps

module mlfr_ctrl
   import mlfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  mlfr_status_type status,
   output mlfr_cmd_type    cmd
);

   mlfr_state_type state_ff, state_in;
   logic           accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HUNT: begin
            if (accept && status.own_match) state_in = ST_SENDER;
         end
         ST_SENDER: begin
            if (accept) state_in = status.sender_match ? ST_DEVICE : ST_HUNT;
         end
         ST_DEVICE: begin
            if (accept) state_in = status.device_match ? ST_PACKET : ST_HUNT;
         end
         ST_PACKET: begin
            if (accept) state_in = ST_LENGTH;
         end
         ST_LENGTH: begin
            if (accept) state_in = status.len_zero ? ST_CHECK : ST_PAYLOAD;
         end
         ST_PAYLOAD: begin
            if (accept) begin
               if (status.count_overflow)  state_in = ST_HUNT;
               else if (status.count_done) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (accept) state_in = status.sum_ok ? ST_REPLAY_READ : ST_HUNT;
         end
         ST_REPLAY_READ: begin
            state_in = ST_REPLAY_LOAD;
         end
         ST_REPLAY_LOAD: begin
            if (status.out_free) state_in = status.replay_last ? ST_HUNT : ST_REPLAY_READ;
         end
         default: state_in = ST_HUNT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_HUNT: begin
            req_ready    = 1'b1;
            cmd.sum_load = accept && status.own_match;
         end
         ST_SENDER: begin
            req_ready    = 1'b1;
            cmd.sum_add  = accept && status.sender_match;
            cmd.src_load = accept && status.sender_match;
         end
         ST_DEVICE: begin
            req_ready   = 1'b1;
            cmd.sum_add = accept && status.device_match;
         end
         ST_PACKET: begin
            req_ready    = 1'b1;
            cmd.sum_add  = accept;
            cmd.pkt_load = accept;
         end
         ST_LENGTH: begin
            req_ready    = 1'b1;
            cmd.sum_add  = accept;
            cmd.len_load = accept;
         end
         ST_PAYLOAD: begin
            req_ready       = 1'b1;
            cmd.sum_add     = accept;
            cmd.store_write = accept;
         end
         ST_CHECK: begin
            req_ready     = 1'b1;
            cmd.sum_add   = accept;
            cmd.idx_clear = accept && status.sum_ok;
         end
         ST_REPLAY_READ: begin
            cmd.rd_issue = 1'b1;
         end
         ST_REPLAY_LOAD: begin
            cmd.out_load = status.out_free;
            cmd.idx_inc  = status.out_free && !status.replay_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/mlfr_dp.sv =====
// Datapath of the link frame receiver: header fields, checksum, payload memory, result register.
`timescale 1ns / 1ps

module mlfr_dp
   import mlfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mlfr_cfg_type       cfg,
   input  logic [BYTE_W-1:0]  rx_byte,
   input  mlfr_cmd_type       cmd,
   output mlfr_status_type    status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_source_id,
   output logic [BYTE_W-1:0]  rsp_packet_id,
   output logic [COUNT_W-1:0] rsp_payload_length,
   output logic [COUNT_W-1:0] rsp_byte_index,
   output logic [BYTE_W-1:0]  rsp_payload_byte,
   output logic               rsp_last
);

   logic [BYTE_W-1:0]  running_sum_ff, running_sum_in;
   logic [BYTE_W-1:0]  held_source_ff;
   logic [BYTE_W-1:0]  held_packet_ff;
   logic [BYTE_W-1:0]  expected_length_ff;
   logic [COUNT_W-1:0] received_count_ff;
   logic [COUNT_W:0]   count_next;
   logic [COUNT_W-1:0] replay_idx_ff;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [BYTE_W-1:0]  store [0:STORE_DEPTH-1];
   logic               frame_empty;
   logic [COUNT_W-1:0] replay_len;

   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_source_ff;
   logic [BYTE_W-1:0]  out_packet_ff;
   logic [COUNT_W-1:0] out_length_ff;
   logic [COUNT_W-1:0] out_index_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_last_ff;

   assign running_sum_in = running_sum_ff + rx_byte;
   assign count_next     = {1'b0, received_count_ff} + (COUNT_W+1)'(1);
   assign frame_empty    = (expected_length_ff == '0);
   assign replay_len     = expected_length_ff[COUNT_W-1:0];

   always_comb begin
      status.own_match      = (rx_byte == cfg.own_address);
      status.sender_match   = (rx_byte == cfg.sender_a) || (rx_byte == cfg.sender_b);
      status.device_match   = (rx_byte == DEVICE_ID_SELF) || (rx_byte == cfg.broadcast_address);
      status.len_zero       = (rx_byte == '0);
      status.count_done     = ({1'b0, count_next} >= expected_length_ff);
      status.count_overflow = (count_next >= (COUNT_W+1)'(MAX_DATA));
      status.sum_ok         = (running_sum_in == '0);
      status.replay_last    = frame_empty || (replay_idx_ff == replay_len - COUNT_W'(1));
      status.out_free       = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff     <= '0;
         held_source_ff     <= '0;
         held_packet_ff     <= '0;
         expected_length_ff <= '0;
         received_count_ff  <= '0;
         replay_idx_ff      <= '0;
         out_valid_ff       <= 1'b0;
      end else begin
         if (cmd.sum_load) running_sum_ff <= rx_byte;
         else if (cmd.sum_add) running_sum_ff <= running_sum_in;
         if (cmd.src_load) held_source_ff <= rx_byte;
         if (cmd.pkt_load) held_packet_ff <= rx_byte;
         if (cmd.len_load) begin
            expected_length_ff <= rx_byte;
            received_count_ff  <= '0;
         end else if (cmd.store_write) begin
            received_count_ff <= count_next[COUNT_W-1:0];
         end
         if (cmd.idx_clear) replay_idx_ff <= '0;
         else if (cmd.idx_inc) replay_idx_ff <= replay_idx_ff + COUNT_W'(1);
         if (cmd.out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // Payload memory: one write port for reception, one registered read port for replay.
   always_ff @(posedge clock) begin
      if (cmd.store_write) store[received_count_ff[STORE_AW-1:0]] <= rx_byte;
      if (cmd.rd_issue) rd_data_ff <= store[replay_idx_ff[STORE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_source_ff <= held_source_ff;
         out_packet_ff <= held_packet_ff;
         out_length_ff <= replay_len;
         out_index_ff  <= replay_idx_ff;
         out_byte_ff   <= frame_empty ? '0 : rd_data_ff;
         out_last_ff   <= status.replay_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_source_id      = out_source_ff;
   assign rsp_packet_id      = out_packet_ff;
   assign rsp_payload_length = out_length_ff;
   assign rsp_byte_index     = out_index_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_last           = out_last_ff;

`ifndef ASSERT_OFF
   // A result is never loaded over one that has not yet been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // Reception and replay never share the payload memory in one cycle.
   a_no_write_in_replay: assert property (@(posedge clock) disable iff (reset)
      cmd.store_write |-> !(cmd.rd_issue || cmd.out_load))
      else $error("payload write during replay");

   // A replayed frame is always shorter than the abort limit.
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (expected_length_ff < BYTE_W'(MAX_DATA)))
      else $error("replayed frame exceeds payload limit");
`endif

endmodule

// ===== rtl/core/motor_link_frame_receiver.sv =====
// Top level of the link frame receiver: register file, controller and datapath.
`timescale 1ns / 1ps

// The receiver takes link bytes one transaction at a time on req_chan and hunts for a frame of
// receiver id, sender id, device id, packet id, length, payload and checksum byte, where the
// 8-bit sum of all frame bytes must be zero. Any header mismatch drops back to the hunt without
// testing the rejected byte again, and a payload run that reaches 64 bytes aborts the frame. While
// hunting and receiving the block takes one byte per clock cycle. When a frame passes its checksum
// the block stops taking bytes and replays the stored payload on rsp_chan, one result transaction
// per payload byte (or a single empty result for a zero-length frame), with last set on the final
// one. Each replayed result passes through a read state and then a load state, as the payload
// memory has a registered read port; the input stays held off until the last result is loaded,
// later if results stall. The result register decouples the two sides: the next frame's bytes are
// taken while the final result of the previous frame still waits. The payload memory needs no
// clearing after reset, as replay only reads entries written by the same frame. Configuration
// registers (own address, two sender ids, broadcast id) sit at byte addresses 0, 4, 8 and 12 of
// the APB-style port and are to be written only while the block is idle.

module motor_link_frame_receiver
   import mlfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   mlfr_req_if.sink          req_chan,
   mlfr_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   mlfr_cfg_type    cfg;
   mlfr_cmd_type    cmd;
   mlfr_status_type status;
   logic            req_ready;

   mlfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The controller sequences the frame; it alone decides when a byte transaction is taken.
   mlfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // The datapath holds the header fields, checksum, payload memory and result register.
   mlfr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .rx_byte            (req_chan.rx_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_source_id      (rsp_chan.source_id),
      .rsp_packet_id      (rsp_chan.packet_id),
      .rsp_payload_length (rsp_chan.payload_length),
      .rsp_byte_index     (rsp_chan.byte_index),
      .rsp_payload_byte   (rsp_chan.payload_byte),
      .rsp_last           (rsp_chan.last)
   );

endmodule
